// File: design/cdli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cdli_pkg;

  localparam int unsigned LOG_BYTES    = 4096;
  localparam int unsigned RECORD_BYTES = 8;
  localparam int unsigned ADDR_W       = $clog2(LOG_BYTES);

  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned FILT_W   = 24;
  localparam int unsigned ACC_W    = 28;
  localparam int unsigned MUL_W    = 29;
  localparam int unsigned PROD_W   = 2 * MUL_W;
  localparam int unsigned RECIP_SH = 32;

  // ceil(2^32 / 10): exact quotient for any dividend below 2^30
  localparam logic [MUL_W-1:0] RECIP_TEN = MUL_W'(429496730);

  localparam logic [LEVEL_W-1:0] TRIGGER_RESET = 16'd49152;
  localparam logic [LEVEL_W-1:0] RELEASE_RESET = 16'd19661;

  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER = 2'd0,
    CFG_RELEASE = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        time_ms;
  } in_t;

  typedef struct packed {
    logic [FILT_W-1:0] filtered_level;
    logic              crash_event;
    logic [ADDR_W-1:0] record_address;
    logic [31:0]       record_time;
    logic              latched;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQ_SUM,
    ST_ROOT,
    ST_ROOT_WAIT,
    ST_MUL,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// File: design/cdli_mult.sv
`timescale 1ns / 1ps
`default_nettype none

module cdli_mult
  import cdli_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [MUL_W-1:0]  a,
  input  wire logic [MUL_W-1:0]  b,
  output logic      [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

`default_nettype wire

// File: design/cdli_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring square root, two radicand bits per cycle.
module cdli_sqrt
  import cdli_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] radicand,
  output logic             done,
  output logic [15:0]      root
);

  logic [31:0] rad;
  logic [16:0] rem;
  logic [3:0]  cnt;
  logic        busy;
  logic [18:0] rem_sh;
  logic [18:0] trial;
  logic        fits;

  always_comb begin
    rem_sh = {rem, rad[31:30]};
    trial  = {1'b0, root, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 4'd15);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == 4'd15)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rad  <= {rad[29:0], 2'b00};
      rem  <= fits ? 17'(rem_sh - trial) : rem_sh[16:0];
      root <= {root[14:0], fits};
      cnt  <= cnt + 4'd1;
    end
  end

endmodule

`default_nettype wire

// File: design/crash_detector_with_log_index.sv
`timescale 1ns / 1ps
`default_nettype none

// Crash detector: per accelerometer word it squares the three axes on one
// shared multiplier, takes the truncated integer square root (two bits per
// cycle), low-pass filters it as (7*old + 3*new)/10 in Q16.8 (the
// divide by ten reuses the multiplier with a reciprocal), then applies the
// trigger/release hysteresis and hands out the log address of each new crash.
// The time per input word is set mostly by the square-root loop;
// in_stall is high while a word is in work. The result sits in an output
// register, so the next input word is taken while the last result waits.
// Config writes: index 0 trigger level, index 1 release level (counts).
module crash_detector_with_log_index
  import cdli_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEVEL_W-1:0]   cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_t                      out_data
);

  state_t state;
  state_t state_next;

  logic [LEVEL_W-1:0] trigger_level;
  logic [LEVEL_W-1:0] release_level;
  logic [FILT_W-1:0]  filter_value;
  logic               crash_latch;
  logic [ADDR_W-1:0]  log_index;

  in_t                item;
  logic [31:0]        sum;
  logic [ACC_W-1:0]   acc;

  logic [MUL_W-1:0]   mul_a;
  logic [PROD_W-1:0]  prod;
  logic               root_start;
  logic               root_done;
  logic [15:0]        root;

  logic               take;
  logic               load_out;
  logic [FILT_W-1:0]  filt_new;
  logic               event_hit;
  logic               latch_new;
  logic [ADDR_W:0]    index_inc;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    abs16 = v[15] ? 16'(~v + 16'd1) : 16'(v);
  endfunction

  assign take     = in_valid && !in_stall;
  assign load_out = (state == ST_FINISH) && (!out_valid || !out_stall);

  cdli_mult u_mult (
    .clk (clk),
    .a   (mul_a),
    .b   ((state == ST_MUL || state == ST_FINISH) ? RECIP_TEN : mul_a),
    .p   (prod)
  );

  cdli_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (sum),
    .done     (root_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    root_start = 1'b0;
    mul_a      = '0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_SQ_X;
        end
      end
      ST_SQ_X: begin
        mul_a      = MUL_W'(abs16(item.accel_x));
        state_next = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        mul_a      = MUL_W'(abs16(item.accel_y));
        state_next = ST_SQ_Z;
      end
      ST_SQ_Z: begin
        mul_a      = MUL_W'(abs16(item.accel_z));
        state_next = ST_SQ_SUM;
      end
      ST_SQ_SUM: begin
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        root_start = 1'b1;
        state_next = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (root_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL, ST_FINISH: begin
        // hold the divide operands so the product stays put while stalled
        mul_a = MUL_W'(acc);
        if (state == ST_MUL) begin
          state_next = ST_FINISH;
        end else if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // crash decision on the new filter level
  always_comb begin
    filt_new  = prod[RECIP_SH +: FILT_W];
    event_hit = (filt_new > {trigger_level, 8'h00}) && !crash_latch;
    latch_new = crash_latch || event_hit;
    if (filt_new < {release_level, 8'h00}) begin
      latch_new = 1'b0;
    end
    index_inc = (ADDR_W + 1)'(log_index) + (ADDR_W + 1)'(RECORD_BYTES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_level <= TRIGGER_RESET;
      release_level <= RELEASE_RESET;
      filter_value  <= '0;
      crash_latch   <= 1'b0;
      log_index     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_TRIGGER: trigger_level <= cfg_data;
          CFG_RELEASE: release_level <= cfg_data;
          default: begin
          end
        endcase
      end
      if (load_out) begin
        out_valid    <= 1'b1;
        filter_value <= filt_new;
        crash_latch  <= latch_new;
        if (event_hit) begin
          // advance one record, drop back to the start at the log end
          if (index_inc >= (ADDR_W + 1)'(LOG_BYTES)) begin
            log_index <= '0;
          end else begin
            log_index <= index_inc[ADDR_W-1:0];
          end
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= in_data;
    end
    case (state)
      ST_SQ_Y:   sum <= prod[31:0];
      ST_SQ_Z:   sum <= sum + prod[31:0];
      ST_SQ_SUM: sum <= sum + prod[31:0];
      default: begin
      end
    endcase
    if (state == ST_ROOT_WAIT && root_done) begin
      acc <= ACC_W'({filter_value, 3'b000}) - ACC_W'(filter_value)
           + ACC_W'({root, 8'h00}) + ACC_W'({root, 9'h000});
    end
    if (load_out) begin
      out_data.filtered_level <= filt_new;
      out_data.crash_event    <= event_hit;
      out_data.record_address <= event_hit ? log_index : '0;
      out_data.record_time    <= event_hit ? item.time_ms : '0;
      out_data.latched        <= latch_new;
    end
  end

endmodule

`default_nettype wire
